// ===== rtl/core/multi_channel_soft_timer_table_defines.svh =====
// Assertion macros shared by the timer table RTL.
`ifndef MULTI_CHANNEL_SOFT_TIMER_TABLE_DEFINES_SVH
`define MULTI_CHANNEL_SOFT_TIMER_TABLE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MCSTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mcstt: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define MCSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mcstt: next-cycle check failed");

`endif

// ===== rtl/core/mcstt_pkg.sv =====
package mcstt_pkg;

	localparam int DEF_NUM_SLOTS   = 8;
	localparam int DEF_COUNT_WIDTH = 32;
	localparam int MAX_RESULTS     = 8;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_CREATE = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_PAUSE  = 3'd3;
	localparam logic [2:0] OP_RESUME = 3'd4;
	localparam logic [2:0] OP_RESET  = 3'd5;
	localparam logic [2:0] OP_GET    = 3'd6;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FAIL = 1'b1;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  slot;
		logic        hit;
		logic [31:0] reload;
		logic        auto_reload;
		logic        run_enable;
	} cmd_t;

endpackage

// ===== rtl/core/mcstt_ram.sv =====
module mcstt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/mcstt_front.sv =====
module mcstt_front #(
	parameter int NUM_SLOTS = mcstt_pkg::DEF_NUM_SLOTS
) (
	input  logic              [2:0]  op,
	input  logic              [2:0]  timer_slot,
	input  logic              [31:0] reload_value,
	input  logic                     auto_reload,
	input  logic                     run_enable,
	output mcstt_pkg::cmd_t          cmd
);

	localparam logic [6:0] SLOTS7 = 7'(NUM_SLOTS);

	logic [6:0] slot_ext;

	assign slot_ext = {4'b0, timer_slot};

	always_comb begin
		cmd.op          = op;
		cmd.slot        = timer_slot;
		// A slot number past the end of the table is treated as not found.
		cmd.hit         = (slot_ext < SLOTS7);
		cmd.reload      = reload_value;
		cmd.auto_reload = auto_reload;
		cmd.run_enable  = run_enable;
	end

endmodule

// ===== rtl/core/mcstt_queue.sv =====
`include "multi_channel_soft_timer_table_defines.svh"

module mcstt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mcstt_pkg::cmd_t push_data,
	input  logic            pop,
	output mcstt_pkg::cmd_t head,
	output logic            empty,
	output logic            full
);

	localparam int DEPTH = mcstt_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	mcstt_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNTW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`MCSTT_ASSERT_NOW(a_pop_not_empty, clk, arst_n, pop, count_q != '0)

endmodule

// ===== rtl/core/mcstt_back.sv =====
`include "multi_channel_soft_timer_table_defines.svh"

module mcstt_back #(
	parameter int NUM_SLOTS   = mcstt_pkg::DEF_NUM_SLOTS,
	parameter int COUNT_WIDTH = mcstt_pkg::DEF_COUNT_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  mcstt_pkg::cmd_t q_head,
	output logic            q_pop,
	output logic            res_valid,
	input  logic            res_ready,
	output logic            kind,
	output logic [2:0]      slot,
	output logic            status,
	output logic            running,
	output logic [31:0]     tick_count,
	output logic            last
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = COUNT_WIDTH;
	localparam int NW = $clog2(mcstt_pkg::MAX_RESULTS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RST  = 3'd2;
	localparam logic [2:0] S_RESP = 3'd3;
	localparam logic [2:0] S_TRD  = 3'd4;
	localparam logic [2:0] S_TUPD = 3'd5;
	localparam logic [2:0] S_TEND = 3'd6;

	logic [2:0]           state_q;
	mcstt_pkg::cmd_t      cmd_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [NUM_SLOTS-1:0] running_q;
	logic [NUM_SLOTS-1:0] auto_q;
	logic [31:0]          ticks_q;
	logic [SW-1:0]        idx_q;
	logic [NW-1:0]        fired_n_q;
	logic                 pend_valid_q;
	logic [2:0]           pend_slot_q;
	logic                 pend_running_q;
	logic                 resp_status_q;
	logic                 resp_running_q;
	logic                 res_valid_q;
	logic                 res_kind_q;
	logic [2:0]           res_slot_q;
	logic                 res_status_q;
	logic                 res_running_q;
	logic [31:0]          res_ticks_q;
	logic                 res_last_q;

	logic [6:0]    cmd_slot_ext;
	logic [SW-1:0] cmd_idx;
	logic [63:0]   rv_ext;
	logic [CW-1:0] rv;
	logic          found;
	logic          free_slot;
	logic [6:0]    idx_ext;
	logic [2:0]    idx_slot;
	logic          sweeping;
	logic          act;
	logic [CW-1:0] dec;
	logic          fire;
	logic          report;
	logic          need_emit;
	logic          stall;
	logic          out_free;
	logic          exec_status;
	logic          exec_running;
	logic          in_tupd;
	logic          in_idle;
	logic          tend_done;

	logic          res_load;
	logic          ld_kind;
	logic [2:0]    ld_slot;
	logic          ld_status;
	logic          ld_running;
	logic          ld_last;

	logic          rld_we;
	logic          cnt_we;
	logic [SW-1:0] ram_raddr;
	logic [SW-1:0] cnt_waddr;
	logic [CW-1:0] cnt_wdata;
	logic [CW-1:0] rld_rd;
	logic [CW-1:0] cnt_rd;

	assign cmd_slot_ext = {4'b0, cmd_q.slot};
	assign cmd_idx      = cmd_slot_ext[SW-1:0];
	assign rv_ext       = {32'b0, cmd_q.reload};
	assign rv           = rv_ext[CW-1:0];
	assign found        = cmd_q.hit && valid_q[cmd_idx];
	assign free_slot    = cmd_q.hit && !valid_q[cmd_idx];

	assign idx_ext  = 7'(idx_q);
	assign idx_slot = idx_ext[2:0];
	assign sweeping = (state_q == S_TRD) || (state_q == S_TUPD);

	// Tick step for the slot under the sweep index; RAM data belongs to idx_q.
	assign act       = valid_q[idx_q] && running_q[idx_q];
	assign dec       = (cnt_rd != '0) ? cnt_rd - CW'(1) : cnt_rd;
	assign fire      = (state_q == S_TUPD) && act && (dec == '0);
	assign report    = fire && (fired_n_q < NW'(mcstt_pkg::MAX_RESULTS));
	assign out_free  = !res_valid_q || res_ready;
	// The held fired result goes out mid-sweep only once a later one proves it is not last.
	assign need_emit = report && pend_valid_q;
	assign stall     = need_emit && !out_free;

	assign in_tupd   = (state_q == S_TUPD);
	assign in_idle   = (state_q == S_IDLE);
	assign tend_done = (state_q == S_TEND) && out_free;

	assign q_pop = (state_q == S_IDLE) && !q_empty;

	always_comb begin
		exec_status  = mcstt_pkg::STAT_FAIL;
		exec_running = 1'b0;
		unique case (cmd_q.op) inside
			mcstt_pkg::OP_CREATE: begin
				if (free_slot) begin
					exec_status = mcstt_pkg::STAT_OK;
				end
			end
			mcstt_pkg::OP_REMOVE, mcstt_pkg::OP_PAUSE, mcstt_pkg::OP_RESUME,
			mcstt_pkg::OP_RESET: begin
				if (found) begin
					exec_status = mcstt_pkg::STAT_OK;
				end
			end
			mcstt_pkg::OP_GET: begin
				if (found) begin
					exec_status  = mcstt_pkg::STAT_OK;
					exec_running = running_q[cmd_idx];
				end
			end
			default: begin
				exec_status = mcstt_pkg::STAT_FAIL;
			end
		endcase
	end

	always_comb begin
		rld_we    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = cmd_idx;
		cnt_wdata = rv;
		ram_raddr = sweeping ? idx_q : cmd_idx;
		if ((state_q == S_EXEC) && (cmd_q.op == mcstt_pkg::OP_CREATE) && free_slot) begin
			rld_we = 1'b1;
			cnt_we = 1'b1;
		end
		if (state_q == S_RST) begin
			cnt_we    = 1'b1;
			cnt_wdata = rld_rd;
		end
		if ((state_q == S_TUPD) && act && !stall) begin
			cnt_we    = 1'b1;
			cnt_waddr = idx_q;
			cnt_wdata = fire ? rld_rd : dec;
		end
	end

	always_comb begin
		res_load   = 1'b0;
		ld_kind    = mcstt_pkg::KIND_STATUS;
		ld_slot    = cmd_q.slot;
		ld_status  = resp_status_q;
		ld_running = resp_running_q;
		ld_last    = 1'b1;
		case (state_q)
			S_RESP: begin
				res_load = out_free;
			end
			S_TUPD: begin
				res_load   = need_emit && out_free;
				ld_kind    = mcstt_pkg::KIND_FIRED;
				ld_slot    = pend_slot_q;
				ld_status  = mcstt_pkg::STAT_OK;
				ld_running = pend_running_q;
				ld_last    = 1'b0;
			end
			S_TEND: begin
				res_load  = out_free;
				ld_status = mcstt_pkg::STAT_OK;
				if (pend_valid_q) begin
					ld_kind    = mcstt_pkg::KIND_FIRED;
					ld_slot    = pend_slot_q;
					ld_running = pend_running_q;
				end else begin
					ld_slot    = 3'd0;
					ld_running = 1'b0;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	mcstt_ram #(
		.WIDTH(CW),
		.DEPTH(NUM_SLOTS)
	) u_reload_ram (
		.clk  (clk),
		.we   (rld_we),
		.waddr(cmd_idx),
		.wdata(rv),
		.raddr(ram_raddr),
		.rdata(rld_rd)
	);

	mcstt_ram #(
		.WIDTH(CW),
		.DEPTH(NUM_SLOTS)
	) u_counter_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(ram_raddr),
		.rdata(cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			running_q    <= '0;
			auto_q       <= '0;
			ticks_q      <= '0;
			idx_q        <= '0;
			fired_n_q    <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q.op == mcstt_pkg::OP_TICK) begin
						state_q <= S_TRD;
					end else if ((cmd_q.op == mcstt_pkg::OP_RESET) && found) begin
						state_q <= S_RST;
					end else begin
						state_q <= S_RESP;
					end
					unique case (cmd_q.op)
						mcstt_pkg::OP_TICK: begin
							ticks_q      <= ticks_q + 32'd1;
							idx_q        <= '0;
							fired_n_q    <= '0;
							pend_valid_q <= 1'b0;
						end
						mcstt_pkg::OP_CREATE: begin
							if (free_slot) begin
								valid_q[cmd_idx]   <= 1'b1;
								running_q[cmd_idx] <= cmd_q.run_enable;
								auto_q[cmd_idx]    <= cmd_q.auto_reload;
							end
						end
						mcstt_pkg::OP_REMOVE: begin
							if (found) begin
								valid_q[cmd_idx]   <= 1'b0;
								running_q[cmd_idx] <= 1'b0;
								auto_q[cmd_idx]    <= 1'b0;
							end
						end
						mcstt_pkg::OP_PAUSE: begin
							if (found) begin
								running_q[cmd_idx] <= 1'b0;
							end
						end
						mcstt_pkg::OP_RESUME: begin
							if (found) begin
								running_q[cmd_idx] <= 1'b1;
							end
						end
						mcstt_pkg::OP_RESET: begin
							if (found) begin
								running_q[cmd_idx] <= 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				S_RST: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TRD: begin
					state_q <= S_TUPD;
				end
				S_TUPD: begin
					if (!stall) begin
						if (fire) begin
							running_q[idx_q] <= auto_q[idx_q];
						end
						if (report) begin
							pend_valid_q <= 1'b1;
							fired_n_q    <= fired_n_q + 1'b1;
						end
						if (idx_q == SW'(NUM_SLOTS - 1)) begin
							state_q <= S_TEND;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_TRD;
						end
					end
				end
				S_TEND: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (state_q == S_EXEC) begin
			resp_status_q  <= exec_status;
			resp_running_q <= exec_running;
		end
		if ((state_q == S_TUPD) && !stall && report) begin
			pend_slot_q    <= idx_slot;
			pend_running_q <= auto_q[idx_q];
		end
		if (res_load) begin
			res_kind_q    <= ld_kind;
			res_slot_q    <= ld_slot;
			res_status_q  <= ld_status;
			res_running_q <= ld_running;
			res_ticks_q   <= ticks_q;
			res_last_q    <= ld_last;
		end
	end

	assign res_valid  = res_valid_q;
	assign kind       = res_kind_q;
	assign slot       = res_slot_q;
	assign status     = res_status_q;
	assign running    = res_running_q;
	assign tick_count = res_ticks_q;
	assign last       = res_last_q;

	`MCSTT_ASSERT_NEXT(a_stall_holds, clk, arst_n, stall, in_tupd && $stable(cnt_rd) && $stable(idx_q))
	`MCSTT_ASSERT_NOW(a_fired_cap, clk, arst_n, 1'b1, fired_n_q <= NW'(mcstt_pkg::MAX_RESULTS))
	`MCSTT_ASSERT_NEXT(a_tick_ends_last, clk, arst_n, tend_done, res_valid && last && in_idle)

endmodule

// ===== rtl/core/multi_channel_soft_timer_table.sv =====
// Channel   Handshake               Payload
// request   req_valid / req_ready   op, timer_slot, reload_value, auto_reload, run_enable
// result    res_valid / res_ready   kind, slot, status, running, tick_count, last
//
// A command passes from the head of the queue through the execute and respond states
// to its result register, a found reset via a reload-copy state. A tick sweeps the slots in
// order with a read and an update state per slot, for registered counter and reload reads.
// Reset clears the slot flags and tick count at once; there is no clearing pass.
// A two-entry request queue keeps accepting until full while a result waits in the output register;
// a tick sweep holds on a slot while a fired result cannot yet be handed over.
module multi_channel_soft_timer_table #(
	parameter int NUM_SLOTS   = mcstt_pkg::DEF_NUM_SLOTS,
	parameter int COUNT_WIDTH = mcstt_pkg::DEF_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  op,
	input  logic [2:0]  timer_slot,
	input  logic [31:0] reload_value,
	input  logic        auto_reload,
	input  logic        run_enable,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        kind,
	output logic [2:0]  slot,
	output logic        status,
	output logic        running,
	output logic [31:0] tick_count,
	output logic        last
);

	mcstt_pkg::cmd_t front_cmd;
	mcstt_pkg::cmd_t q_head;
	logic            q_empty;
	logic            q_full;
	logic            q_pop;
	logic            push;

	assign req_ready = !q_full;
	assign push      = req_valid && req_ready;

	mcstt_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.op          (op),
		.timer_slot  (timer_slot),
		.reload_value(reload_value),
		.auto_reload (auto_reload),
		.run_enable  (run_enable),
		.cmd         (front_cmd)
	);

	mcstt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(front_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	mcstt_back #(
		.NUM_SLOTS  (NUM_SLOTS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.kind      (kind),
		.slot      (slot),
		.status    (status),
		.running   (running),
		.tick_count(tick_count),
		.last      (last)
	);

endmodule

// ===== tb/tb_multi_channel_soft_timer_table.sv =====
`timescale 1ns / 100ps

module tb_multi_channel_soft_timer_table;

	localparam int          SLOTS       = mcstt_pkg::DEF_NUM_SLOTS;
	localparam logic [2:0]  OP_UNKNOWN  = 3'd7;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          DRAIN_WAIT  = 2 * SLOTS + 40;
	localparam int          HOLD_CYCLES = 300;
	localparam int          RANDOM_REQS = 104;

	typedef struct packed {
		logic        kind;
		logic [2:0]  slot;
		logic        status;
		logic        running;
		logic [31:0] tick_count;
		logic        last;
	} timer_result_t;

	// Mirrors the slot table and keeps the results each request should produce.
	class slot_table_tracker;
		bit          used[SLOTS];
		bit          run[SLOTS];
		bit          rearm[SLOTS];
		bit [31:0]   reload[SLOTS];
		bit [31:0]   count[SLOTS];
		bit [31:0]   ticks;
		timer_result_t due_results[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned expiries;
		int unsigned requests;
		int unsigned tick_reqs;

		function void push_due(logic k, logic [2:0] idx, logic st, logic rn);
			timer_result_t r;
			r.kind = k;
			r.slot = idx;
			r.status = st;
			r.running = rn;
			r.tick_count = ticks;
			r.last = 1'b0;
			due_results.push_back(r);
		endfunction

		function void note_request(logic [2:0] op, logic [2:0] idx, logic [31:0] rv,
				logic ar, logic re);
			int   fired;
			logic hit;
			logic st;
			logic rn;
			requests++;
			fired = 0;
			hit = used[idx];
			st = mcstt_pkg::STAT_FAIL;
			rn = 1'b0;
			if (op == mcstt_pkg::OP_TICK) begin
				tick_reqs++;
				ticks++;
				for (int i = 0; i < SLOTS; i++) begin
					if (!used[i] || !run[i])
						continue;
					if (count[i] != 0)
						count[i]--;
					if (count[i] == 0) begin
						count[i] = reload[i];
						if (!rearm[i])
							run[i] = 1'b0;
						if (fired < mcstt_pkg::MAX_RESULTS) begin
							push_due(mcstt_pkg::KIND_FIRED, i[2:0], mcstt_pkg::STAT_OK,
								run[i]);
							fired++;
							expiries++;
						end
					end
				end
				if (fired == 0)
					push_due(mcstt_pkg::KIND_STATUS, 3'd0, mcstt_pkg::STAT_OK, 1'b0);
			end else begin
				case (op)
					mcstt_pkg::OP_CREATE: if (!hit) begin
						used[idx] = 1'b1;
						rearm[idx] = ar;
						run[idx] = re;
						reload[idx] = rv;
						count[idx] = rv;
						st = mcstt_pkg::STAT_OK;
					end
					mcstt_pkg::OP_REMOVE: if (hit) begin
						used[idx] = 1'b0;
						run[idx] = 1'b0;
						rearm[idx] = 1'b0;
						reload[idx] = '0;
						count[idx] = '0;
						st = mcstt_pkg::STAT_OK;
					end
					mcstt_pkg::OP_PAUSE: if (hit) begin
						run[idx] = 1'b0;
						st = mcstt_pkg::STAT_OK;
					end
					mcstt_pkg::OP_RESUME: if (hit) begin
						run[idx] = 1'b1;
						st = mcstt_pkg::STAT_OK;
					end
					mcstt_pkg::OP_RESET: if (hit) begin
						count[idx] = reload[idx];
						run[idx] = 1'b1;
						st = mcstt_pkg::STAT_OK;
					end
					mcstt_pkg::OP_GET: if (hit) begin
						rn = run[idx];
						st = mcstt_pkg::STAT_OK;
					end
					default: ;
				endcase
				push_due(mcstt_pkg::KIND_STATUS, idx, st, rn);
			end
			due_results[due_results.size() - 1].last = 1'b1;
		endfunction

		function void check_result(timer_result_t got);
			timer_result_t want;
			checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result kind=%0d slot=%0d status=%0d %s%0d %s%0d %s%0d",
						$realtime, got.kind, got.slot, got.status,
						"running=", got.running, "ticks=", got.tick_count,
						"last=", got.last);
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind || got.slot !== want.slot ||
					got.status !== want.status || got.running !== want.running ||
					got.tick_count !== want.tick_count || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch, expected kind=%0d slot=%0d status=%0d %s%0d %s%0d %s%0d",
						$realtime, want.kind, want.slot, want.status,
						"running=", want.running, "ticks=", want.tick_count,
						"last=", want.last);
					$display("%0t:           got      kind=%0d slot=%0d status=%0d %s%0d %s%0d %s%0d",
						$realtime, got.kind, got.slot, got.status,
						"running=", got.running, "ticks=", got.tick_count,
						"last=", got.last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [2:0]  op;
	logic [2:0]  timer_slot;
	logic [31:0] reload_value;
	logic        auto_reload;
	logic        run_enable;
	logic        res_valid;
	logic        res_ready;
	logic        kind;
	logic [2:0]  slot;
	logic        status;
	logic        running;
	logic [31:0] tick_count;
	logic        last;

	logic        random_phase;
	logic        hold_results;
	bit          sender_rush;
	int unsigned cycle_count;

	slot_table_tracker table_state;

	multi_channel_soft_timer_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.op           (op),
		.timer_slot   (timer_slot),
		.reload_value (reload_value),
		.auto_reload  (auto_reload),
		.run_enable   (run_enable),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.kind         (kind),
		.slot         (slot),
		.status       (status),
		.running      (running),
		.tick_count   (tick_count),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				table_state.due_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge where the request is taken.
	// Valid stays high across back-to-back requests so it is never toggled in one step.
	task automatic send_request(logic [2:0] o, logic [2:0] idx, logic [31:0] rv,
			logic ar, logic re);
		int gap;
		if ($urandom_range(0, 15) == 0)
			sender_rush = !sender_rush;
		gap = sender_rush ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		op <= o;
		timer_slot <= idx;
		reload_value <= rv;
		auto_reload <= ar;
		run_enable <= re;
		do
			@(posedge clk);
		while (!req_ready);
		table_state.note_request(o, idx, rv, ar, re);
	endtask

	task automatic send_random_request();
		int          pick;
		logic [2:0]  o;
		logic [31:0] rv;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			o = mcstt_pkg::OP_TICK;
		else if (pick < 55)
			o = mcstt_pkg::OP_CREATE;
		else if (pick < 63)
			o = mcstt_pkg::OP_REMOVE;
		else if (pick < 71)
			o = mcstt_pkg::OP_PAUSE;
		else if (pick < 79)
			o = mcstt_pkg::OP_RESUME;
		else if (pick < 87)
			o = mcstt_pkg::OP_RESET;
		else if (pick < 97)
			o = mcstt_pkg::OP_GET;
		else
			o = OP_UNKNOWN;
		// Short reloads keep timers expiring; a few full-width values exercise every bit.
		pick = $urandom_range(0, 9);
		if (pick < 7)
			rv = $urandom_range(0, 4);
		else if (pick < 9)
			rv = $urandom_range(5, 40);
		else
			rv = $urandom;
		send_request(o, 3'($urandom_range(0, 7)), rv, 1'($urandom), 1'($urandom));
	endtask

	// Receiver: random stalls, with the long hold-off layered on top.
	initial begin
		bit rush;
		int stall;
		timer_result_t got;
		res_ready <= 1'b0;
		rush = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rush = !rush;
			stall = rush ? 0 : $urandom_range(0, 14);
			if (stall > 0 || hold_results) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_results)
					@(posedge clk);
			end
			res_ready <= 1'b1;
			do
				@(posedge clk);
			while (!res_valid);
			got.kind = kind;
			got.slot = slot;
			got.status = status;
			got.running = running;
			got.tick_count = tick_count;
			got.last = last;
			table_state.check_result(got);
		end
	end

	// Long hold-off on the result side so the request queue fills and backs up.
	initial begin
		hold_results <= 1'b0;
		@(posedge clk);
		while (!random_phase)
			@(posedge clk);
		repeat (20) @(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
	end

	initial begin
		table_state = new();
		cycle_count = 0;
		sender_rush = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		op <= mcstt_pkg::OP_TICK;
		timer_slot <= '0;
		reload_value <= '0;
		auto_reload <= 1'b0;
		run_enable <= 1'b0;
		random_phase <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tick on an empty table, then every command but create on an empty slot.
		send_request(mcstt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_GET, 3'd3, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_REMOVE, 3'd3, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_PAUSE, 3'd3, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_RESUME, 3'd3, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_RESET, 3'd3, 32'd0, 1'b0, 1'b0);
		// A zero reload fires on every tick; a second create on a used slot fails.
		send_request(mcstt_pkg::OP_CREATE, 3'd0, 32'd0, 1'b1, 1'b1);
		send_request(mcstt_pkg::OP_CREATE, 3'd0, 32'd5, 1'b0, 1'b1);
		send_request(mcstt_pkg::OP_CREATE, 3'd1, 32'd1, 1'b0, 1'b1);
		send_request(mcstt_pkg::OP_CREATE, 3'd2, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_request(mcstt_pkg::OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_request(mcstt_pkg::OP_GET, 3'd1, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_RESUME, 3'd2, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_PAUSE, 3'd2, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_RESET, 3'd2, 32'd0, 1'b0, 1'b0);
		send_request(OP_UNKNOWN, 3'd5, 32'hA5A5_5A5A, 1'b1, 1'b1);
		send_request(mcstt_pkg::OP_REMOVE, 3'd2, 32'd0, 1'b0, 1'b0);
		// Fill the table so that a single tick expires every slot.
		send_request(mcstt_pkg::OP_CREATE, 3'd2, 32'd0, 1'b0, 1'b1);
		for (int i = 3; i < SLOTS; i++)
			send_request(mcstt_pkg::OP_CREATE, 3'(i), 32'd0, 1'b1, 1'b1);
		send_request(mcstt_pkg::OP_RESUME, 3'd1, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0, 1'b0);
		send_request(mcstt_pkg::OP_TICK, 3'd0, 32'd0, 1'b0, 1'b0);

		random_phase <= 1'b1;
		repeat (RANDOM_REQS) send_random_request();
		req_valid <= 1'b0;

		while (table_state.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run covered %0d requests (%0d ticks) and %0d results, %0d of them expiries.",
			table_state.requests, table_state.tick_reqs, table_state.checked,
			table_state.expiries);
		$display("Mismatched or unexpected results: %0d.", table_state.mismatches);
		if (table_state.mismatches == 0 && table_state.due_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
